// File: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, action codes and the result record of the array edit
// and sort block.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ELEM_W       = 32;
	localparam int POS_W        = 5;
	localparam int ACT_W        = 2;

	// request action codes; the fourth code has no meaning and is an error
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     phase;
		logic                     error;
		logic                     last;
	} aes_res_t;

endpackage

// File: design/aes_if.sv
// ----------------------------------------------------------------------------
// aes_in_if / aes_out_if
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
interface aes_in_if
	import aes_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [POS_W-1:0]         position;
	logic signed [ELEM_W-1:0] value;

	modport source (output valid, output action, output position, output value,
		input ready);
	modport sink (input valid, input action, input position, input value,
		output ready);
endinterface

interface aes_out_if
	import aes_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element;
	logic                     phase;
	logic                     error;
	logic                     last;

	modport source (output valid, output element, output phase, output error,
		output last, input ready);
	modport sink (input valid, input element, input phase, input error,
		input last, output ready);
endinterface

// File: design/array_edit_and_sort_core.sv
// ----------------------------------------------------------------------------
// array_edit_and_sort_core
// Array of signed entries with append, delete and insert, listing the edited
// and the exchange-sorted array after every delete or insert.
// ----------------------------------------------------------------------------
// usage:
//   cmd carries requests (action, position, value); res carries results
//   (element, phase, error, last), both valid/ready.
//   an append gives no result. a delete or insert of an
//   array holding n entries afterwards gives n edited-order results (phase 0)
//   then n sorted results (phase 1), the final one with last set.
//   a bad position, a full array or an unknown action gives a single result
//   with error and last set; the array is left as it was.
//   every step goes through the single read port of the entry store: each entry
//   moved, listed or compared is first read, then written, listed or compared.
//   cmd.ready is high only between requests.
//   results leave through one output register; a stalled receiver holds the
//   sequencer where it is and nothing is lost.
//   reset empties the array (count cleared); entry contents are not cleared.
// ----------------------------------------------------------------------------
module array_edit_and_sort_core
	import aes_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	aes_in_if.sink     cmd,
	aes_out_if.source  res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic signed [ELEM_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [AW-1:0]            mem_raddr;
	logic signed [ELEM_W-1:0] mem_rdata;
	logic                     res_push;
	aes_res_t                 res_d;
	logic                     res_free;
	logic                     out_valid_q;
	aes_res_t                 out_q;

	aes_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	aes_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_push  (res_push),
		.res       (res_d),
		.res_free  (res_free)
	);

	assign res_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res_d;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.element = out_q.element;
	assign res.phase   = out_q.phase;
	assign res.error   = out_q.error;
	assign res.last    = out_q.last;

	// the sequencer never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_free)
		else $error("result pushed into a full output register");

	// no result is produced while the block waits for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !res_push)
		else $error("result pushed while idle");

	// an error result stands alone and closes the request
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_d.error |-> res_d.last && !res_d.phase && res_d.element == '0)
		else $error("malformed error result");

endmodule

// File: design/aes_mem.sv
// ----------------------------------------------------------------------------
// aes_mem
// Entry store: one write port, one read port with registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module aes_mem
	import aes_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(CAPACITY_DEF)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [ELEM_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic signed [ELEM_W-1:0] rdata
);

	logic signed [ELEM_W-1:0] mem_q [DEPTH];
	logic signed [ELEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/aes_seq.sv
// ----------------------------------------------------------------------------
// aes_seq
// Sequencer: takes a request, shifts entries through the store, lists them,
// runs the exchange sort with one signed comparator and lists them again.
// ----------------------------------------------------------------------------
module aes_seq
	import aes_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY_DEF),
	parameter int CW       = $clog2(CAPACITY_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	aes_in_if.sink                   cmd,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic signed [ELEM_W-1:0] mem_wdata,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_raddr,
	input  logic signed [ELEM_W-1:0] mem_rdata,
	output logic                     res_push,
	output aes_res_t                 res,
	input  logic                     res_free
);

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_SHIFT_RD = 11'b000_0000_0010,
		S_SHIFT_WR = 11'b000_0000_0100,
		S_EMIT_RD  = 11'b000_0000_1000,
		S_EMIT_OUT = 11'b000_0001_0000,
		S_SORT_A   = 11'b000_0010_0000,
		S_SORT_CUR = 11'b000_0100_0000,
		S_SORT_RD  = 11'b000_1000_0000,
		S_SORT_CMP = 11'b001_0000_0000,
		S_SORT_WB  = 11'b010_0000_0000,
		S_ERR      = 11'b100_0000_0000
	} state_t;

	state_t                   state_q, state_d;
	logic [ACT_W-1:0]         op_q, op_d;
	logic [AW-1:0]            pos_q, pos_d;
	logic signed [ELEM_W-1:0] val_q, val_d;
	logic [CW-1:0]            count_q, count_d;
	logic [AW-1:0]            n_q, n_d;
	logic [AW-1:0]            a_q, a_d;
	logic [AW-1:0]            b_q, b_d;
	logic [AW-1:0]            e_q, e_d;
	logic                     phase_q, phase_d;
	logic signed [ELEM_W-1:0] cur_q, cur_d;
	logic [CW-1:0]            cnt_m1;
	logic                     e_end, a_end, b_end;

	assign cnt_m1 = count_q - 1'b1;
	assign e_end  = (CW'(e_q) == cnt_m1);
	assign a_end  = (CW'(a_q) == cnt_m1);
	assign b_end  = (CW'(b_q) == cnt_m1);

	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		pos_d     = pos_q;
		val_d     = val_q;
		count_d   = count_q;
		n_d       = n_q;
		a_d       = a_q;
		b_d       = b_q;
		e_d       = e_q;
		phase_d   = phase_q;
		cur_d     = cur_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res_push  = 1'b0;
		res       = '{element: mem_rdata, phase: phase_q, error: 1'b0,
			last: phase_q && e_end};

		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d  = cmd.action;
					pos_d = AW'(cmd.position);
					val_d = cmd.value;
					case (cmd.action)
						ACT_APPEND: begin
							if (count_q == CW'(CAPACITY)) begin
								state_d = S_ERR;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = cmd.value;
								count_d   = count_q + 1'b1;
							end
						end
						ACT_DELETE: begin
							if (CMPW'(cmd.position) >= CMPW'(count_q)) begin
								state_d = S_ERR;
							end else begin
								n_d     = AW'(cmd.position);
								state_d = S_SHIFT_RD;
							end
						end
						ACT_INSERT: begin
							if (count_q == CW'(CAPACITY) ||
								CMPW'(cmd.position) > CMPW'(count_q)) begin
								state_d = S_ERR;
							end else begin
								n_d     = count_q[AW-1:0];
								state_d = S_SHIFT_RD;
							end
						end
						default: begin
							state_d = S_ERR;
						end
					endcase
				end
			end
			S_SHIFT_RD: begin
				e_d     = '0;
				phase_d = 1'b0;
				if (op_q == ACT_DELETE) begin
					if (CW'(n_q) + 1'b1 < count_q) begin
						mem_re    = 1'b1;
						mem_raddr = n_q + 1'b1;
						state_d   = S_SHIFT_WR;
					end else begin
						count_d = count_q - 1'b1;
						// array left empty: nothing to list
						state_d = (count_q == CW'(1)) ? S_IDLE : S_EMIT_RD;
					end
				end else begin
					if (n_q > pos_q) begin
						mem_re    = 1'b1;
						mem_raddr = n_q - 1'b1;
						state_d   = S_SHIFT_WR;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = pos_q;
						mem_wdata = val_q;
						count_d   = count_q + 1'b1;
						state_d   = S_EMIT_RD;
					end
				end
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = n_q;
				mem_wdata = mem_rdata;
				n_d       = (op_q == ACT_DELETE) ? n_q + 1'b1 : n_q - 1'b1;
				state_d   = S_SHIFT_RD;
			end
			S_EMIT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = e_q;
				state_d   = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (res_free) begin
					res_push = 1'b1;
					if (e_end) begin
						a_d     = '0;
						state_d = phase_q ? S_IDLE : S_SORT_A;
					end else begin
						e_d     = e_q + 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			S_SORT_A: begin
				mem_re    = 1'b1;
				mem_raddr = a_q;
				state_d   = S_SORT_CUR;
			end
			S_SORT_CUR: begin
				cur_d   = mem_rdata;
				b_d     = '0;
				state_d = S_SORT_RD;
			end
			S_SORT_RD: begin
				// entry a lives in cur_q during the pass, so skip b == a
				if (b_q == a_q) begin
					b_d     = b_q + 1'b1;
					state_d = b_end ? S_SORT_WB : S_SORT_RD;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = b_q;
					state_d   = S_SORT_CMP;
				end
			end
			S_SORT_CMP: begin
				if (cur_q < mem_rdata) begin
					mem_we    = 1'b1;
					mem_waddr = b_q;
					mem_wdata = cur_q;
					cur_d     = mem_rdata;
				end
				b_d     = b_q + 1'b1;
				state_d = b_end ? S_SORT_WB : S_SORT_RD;
			end
			S_SORT_WB: begin
				mem_we    = 1'b1;
				mem_waddr = a_q;
				mem_wdata = cur_q;
				if (a_end) begin
					e_d     = '0;
					phase_d = 1'b1;
					state_d = S_EMIT_RD;
				end else begin
					a_d     = a_q + 1'b1;
					state_d = S_SORT_A;
				end
			end
			S_ERR: begin
				res = '{element: '0, phase: 1'b0, error: 1'b1, last: 1'b1};
				if (res_free) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			op_q    <= ACT_APPEND;
			n_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			e_q     <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			op_q    <= op_d;
			n_q     <= n_d;
			a_q     <= a_d;
			b_q     <= b_d;
			e_q     <= e_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		cur_q <= cur_d;
	end

endmodule
